[hdl/cpu_bus_decoder_with_sprite_dma_core_assert.svh]
// Assertion macros for the cpu bus decoder with sprite DMA.
// Expects clk and rst_n in the scope of the including module.
`ifndef CPU_BUS_DECODER_WITH_SPRITE_DMA_CORE_ASSERT_SVH
`define CPU_BUS_DECODER_WITH_SPRITE_DMA_CORE_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define CBD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CBD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/cbd_pkg.sv]
// Shared types, codes and address constants of the cpu bus decoder.
// No dependencies.
package cbd_pkg;

    localparam int RAM_BYTES_DEF  = 2048;
    localparam int DMA_LENGTH_DEF = 256;

    localparam logic [1:0] OP_READ     = 2'd0;
    localparam logic [1:0] OP_WRITE    = 2'd1;
    localparam logic [1:0] OP_DMA_TICK = 2'd2;

    localparam logic [15:0] ADDR_PPU_BASE  = 16'h2000;
    localparam logic [15:0] ADDR_APU_BASE  = 16'h4000;
    localparam logic [15:0] ADDR_APU_END   = 16'h4020;
    localparam logic [15:0] ADDR_CART_BASE = 16'h6000;
    localparam logic [15:0] ADDR_DMA_START = 16'h4014;
    localparam logic [15:0] PPU_OAM_DATA   = 16'h0004;
    localparam logic [7:0]  DMA_PAGE_RESET = 8'h02;

    typedef enum logic [2:0] {
        TGT_NONE = 3'd0,
        TGT_RAM  = 3'd1,
        TGT_PPU  = 3'd2,
        TGT_APU  = 3'd3,
        TGT_CART = 3'd4,
        TGT_DMA  = 3'd5
    } target_t;

    function automatic target_t decode_target(input logic [15:0] a);
        target_t t;
        priority if (a < ADDR_PPU_BASE) t = TGT_RAM;
        else if (a < ADDR_APU_BASE)     t = TGT_PPU;
        else if (a < ADDR_APU_END)      t = TGT_APU;
        else if (a >= ADDR_CART_BASE)   t = TGT_CART;
        else                            t = TGT_NONE;
        return t;
    endfunction

endpackage

[hdl/cbd_req_if.sv]
// Request channel of the cpu bus decoder: one bus access or DMA tick per word.
// Depends on nothing.
interface cbd_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  external_data;

    modport source (output valid, operation, address, write_data, external_data, input ready);
    modport sink   (input valid, operation, address, write_data, external_data, output ready);
endinterface

[hdl/cbd_rsp_if.sv]
// Result channel of the cpu bus decoder: one routed access per word.
// Depends on nothing.
interface cbd_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  target;
    logic [15:0] target_address;
    logic        is_write;
    logic [7:0]  out_data;
    logic [7:0]  read_data;
    logic        dma_active;
    logic [15:0] dma_source;

    modport source (output valid, target, target_address, is_write, out_data, read_data,
                    dma_active, dma_source, input ready);
    modport sink   (input valid, target, target_address, is_write, out_data, read_data,
                    dma_active, dma_source, output ready);
endinterface

[hdl/cpu_bus_decoder_with_sprite_dma_core.sv]
// Pipeline: an accepted request word is registered in stage 1, then in the output stage once that is free.
// Throughput: one word per cycle unless the output stalls; stage 1 reads the work RAM port, stage 2 is the output.
// Reset: DMA idle, page 2, pipeline empty; then a clearing pass zeroes the work RAM,
// one byte per cycle through all RAM_BYTES bytes, with req.ready held low.
// Depends on cbd_pkg, cbd_req_if, cbd_rsp_if and the assertion macro header.
`include "cpu_bus_decoder_with_sprite_dma_core_assert.svh"

module cpu_bus_decoder_with_sprite_dma_core
    import cbd_pkg::*;
#(
    parameter int RAM_BYTES  = RAM_BYTES_DEF,
    parameter int DMA_LENGTH = DMA_LENGTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    cbd_req_if.sink       req,
    cbd_rsp_if.source     rsp
);

    localparam int AW     = $clog2(RAM_BYTES);
    localparam int IW     = $clog2(DMA_LENGTH + 1);
    localparam int QSTEPS = $clog2(8192 / RAM_BYTES) + 1;

    typedef struct packed {
        target_t     target;
        logic [15:0] taddr;
        logic        is_wr;
        logic [7:0]  wbyte;
        logic [7:0]  rbyte;
        logic        ram_sel;
        logic        wr_from_rd;
        logic        dma_active;
        logic [15:0] src;
    } stage_t;

    typedef struct packed {
        logic [2:0]  target;
        logic [15:0] taddr;
        logic        is_wr;
        logic [7:0]  odat;
        logic [7:0]  rdat;
        logic        dma_active;
        logic [15:0] src;
    } result_t;

    // Mirror a 13-bit address into the work RAM by restoring subtraction.
    function automatic logic [AW-1:0] ram_index(input logic [12:0] a);
        logic [13:0] r;
        r = {1'b0, a};
        for (int k = QSTEPS - 1; k >= 0; k--) begin
            if (32'(r) >= (RAM_BYTES << k))
            begin
                r = r - 14'(RAM_BYTES << k);
            end
        end
        return r[AW-1:0];
    endfunction

    logic [7:0]    work_ram [RAM_BYTES];
    logic [7:0]    ram_q_reg;
    logic          clearing_reg;
    logic [AW-1:0] clr_idx_reg;

    logic [7:0]    dma_page_reg,  dma_page_next;
    logic [IW-1:0] dma_index_reg, dma_index_next;
    logic          dma_busy_reg,  dma_busy_next;

    stage_t        s1_reg, s1_next;
    logic          s1_valid_reg;
    result_t       out_reg, out_next;
    logic          out_valid_reg;

    logic          out_load, s1_adv, accept, ram_we;
    logic [15:0]   dma_src, sel_addr, dec_off;
    logic [AW-1:0] ram_idx;
    target_t       dec_tgt;

    assign out_load  = !out_valid_reg || rsp.ready;
    assign s1_adv    = s1_valid_reg && out_load;
    assign req.ready = !clearing_reg && (!s1_valid_reg || out_load);
    assign accept    = req.valid && req.ready;

    assign dma_src  = {dma_page_reg, 8'(dma_index_reg)};
    assign sel_addr = (req.operation == OP_DMA_TICK) ? dma_src : req.address;
    assign ram_idx  = ram_index(sel_addr[12:0]);
    assign dec_tgt  = decode_target(sel_addr);

    always_comb
    begin
        unique case (dec_tgt)
            TGT_RAM:  dec_off = 16'(ram_idx);
            TGT_PPU:  dec_off = {13'd0, sel_addr[2:0]};
            TGT_APU:  dec_off = {11'd0, sel_addr[4:0]};
            TGT_CART: dec_off = sel_addr;
            default:  dec_off = '0;
        endcase
    end

    // Decode one request word and work out the DMA state it leaves.
    always_comb
    begin
        s1_next        = '0;
        ram_we         = 1'b0;
        dma_page_next  = dma_page_reg;
        dma_index_next = dma_index_reg;
        dma_busy_next  = dma_busy_reg;
        unique case (req.operation)
            OP_READ:
            begin
                s1_next.target  = dec_tgt;
                s1_next.taddr   = dec_off;
                s1_next.ram_sel = (dec_tgt == TGT_RAM);
                s1_next.rbyte   = (dec_tgt == TGT_RAM || dec_tgt == TGT_NONE) ?
                                  8'd0 : req.external_data;
            end
            OP_WRITE:
            begin
                if (req.address == ADDR_DMA_START)
                begin
                    s1_next.target = TGT_DMA;
                    s1_next.taddr  = ADDR_DMA_START;
                    dma_page_next  = req.write_data;
                    dma_index_next = '0;
                    dma_busy_next  = 1'b1;
                end
                else
                begin
                    s1_next.target = dec_tgt;
                    s1_next.taddr  = dec_off;
                    ram_we         = accept && (dec_tgt == TGT_RAM);
                end
                if (s1_next.target != TGT_NONE)
                begin
                    s1_next.is_wr = 1'b1;
                    s1_next.wbyte = req.write_data;
                end
            end
            OP_DMA_TICK:
            begin
                if (dma_busy_reg)
                begin
                    if (32'(dma_index_reg) < DMA_LENGTH)
                    begin
                        s1_next.src        = dma_src;
                        s1_next.target     = TGT_PPU;
                        s1_next.taddr      = PPU_OAM_DATA;
                        s1_next.is_wr      = 1'b1;
                        s1_next.wr_from_rd = 1'b1;
                        s1_next.ram_sel    = (dec_tgt == TGT_RAM);
                        s1_next.rbyte      = (dec_tgt == TGT_RAM || dec_tgt == TGT_NONE) ?
                                             8'd0 : req.external_data;
                        dma_index_next     = IW'(dma_index_reg + 1'b1);
                    end
                    else
                    begin
                        // final tick: end the DMA, report an empty result
                        dma_busy_next  = 1'b0;
                        dma_index_next = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        s1_next.dma_active = dma_busy_next;
    end

    always_comb
    begin
        out_next.target     = s1_reg.target;
        out_next.taddr      = s1_reg.taddr;
        out_next.is_wr      = s1_reg.is_wr;
        out_next.rdat       = s1_reg.ram_sel ? ram_q_reg : s1_reg.rbyte;
        out_next.odat       = s1_reg.wr_from_rd ? out_next.rdat : s1_reg.wbyte;
        out_next.dma_active = s1_reg.dma_active;
        out_next.src        = s1_reg.src;
    end

    // Work RAM: clearing pass after reset, then cpu writes; read data registered.
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            work_ram[clr_idx_reg] <= '0;
        end
        else if (ram_we)
        begin
            work_ram[ram_idx] <= req.write_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ram_q_reg <= work_ram[ram_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (clr_idx_reg == AW'(RAM_BYTES - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dma_page_reg  <= DMA_PAGE_RESET;
            dma_index_reg <= '0;
            dma_busy_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                dma_page_reg  <= dma_page_next;
                dma_index_reg <= dma_index_next;
                dma_busy_reg  <= dma_busy_next;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
        if (s1_adv)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.target         = out_reg.target;
    assign rsp.target_address = out_reg.taddr;
    assign rsp.is_write       = out_reg.is_wr;
    assign rsp.out_data       = out_reg.odat;
    assign rsp.read_data      = out_reg.rdat;
    assign rsp.dma_active     = out_reg.dma_active;
    assign rsp.dma_source     = out_reg.src;

    `CBD_ASSERT(a_no_accept_while_clearing, clearing_reg |-> !req.ready, "word accepted during RAM clear")
    `CBD_ASSERT(a_index_in_range, 32'(dma_index_reg) <= DMA_LENGTH, "DMA index past transfer length")
    `CBD_ASSERT(a_none_is_quiet, (rsp.valid && rsp.target == TGT_NONE) |-> (!rsp.is_write && rsp.out_data == 8'd0 && rsp.target_address == 16'd0), "unrouted result carries data")
    `CBD_ASSERT_NEXT(a_dma_start, accept && req.operation == OP_WRITE && req.address == ADDR_DMA_START, dma_busy_reg && dma_index_reg == '0, "DMA start did not arm the transfer")

endmodule

[verif/testbench.sv]
// Self-checking testbench for the cpu bus decoder with sprite DMA.
// Needs cbd_pkg, the cbd_req_if and cbd_rsp_if interfaces and the core.
// Predicts each result word from a local copy of the RAM and DMA state.
`timescale 1ns / 1ps

module testbench;
    import cbd_pkg::*;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         RANDOM_ITEMS = 1050;
    localparam int         IDLE_LIMIT   = 8000;
    localparam int         REPORT_MAX   = 10;
    localparam int         TAIL_CYCLES  = 8;

    typedef struct packed {
        target_t     target;
        logic [15:0] target_address;
        logic        is_write;
        logic [7:0]  out_data;
        logic [7:0]  read_data;
        logic        dma_active;
        logic [15:0] dma_source;
    } route_t;

    logic clk;
    logic rst_n;

    cbd_req_if req_bus ();
    cbd_rsp_if rsp_bus ();

    cpu_bus_decoder_with_sprite_dma_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // Local copy of the block state
    logic [7:0] work_mem [RAM_BYTES_DEF];
    logic [7:0] dma_page;
    logic [8:0] dma_count;
    logic       dma_running;

    route_t expected_routes [$];
    int     fail_count;
    int     items_sent;
    int     burst_left;
    bit     gaps_on;
    bit     stall_enable;
    int     hold_off_left;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int ram_index(input logic [15:0] a);
        return int'(a[12:0]) % RAM_BYTES_DEF;
    endfunction

    function automatic void map_address(input logic [15:0] a, output target_t t,
                                        output logic [15:0] off);
        if (a < ADDR_PPU_BASE)
        begin
            t   = TGT_RAM;
            off = 16'(ram_index(a));
        end
        else if (a < ADDR_APU_BASE)
        begin
            t   = TGT_PPU;
            off = {13'd0, a[2:0]};
        end
        else if (a < ADDR_APU_END)
        begin
            t   = TGT_APU;
            off = {11'd0, a[4:0]};
        end
        else if (a >= ADDR_CART_BASE)
        begin
            t   = TGT_CART;
            off = a;
        end
        else
        begin
            t   = TGT_NONE;
            off = '0;
        end
    endfunction

    function automatic logic [7:0] bus_byte(input target_t t, input logic [15:0] off,
                                            input logic [7:0] ext);
        if (t == TGT_RAM)
            return work_mem[int'(off)];
        if (t == TGT_NONE)
            return 8'h00;
        return ext;
    endfunction

    // Route one accepted word and update the local state
    function automatic route_t route_access(input logic [1:0] op, input logic [15:0] addr,
                                            input logic [7:0] wd, input logic [7:0] ext);
        route_t      r;
        target_t     t;
        logic [15:0] off;
        logic [15:0] src;
        r = '0;
        case (op)
            OP_READ:
            begin
                map_address(addr, t, off);
                r.target         = t;
                r.target_address = off;
                r.read_data      = bus_byte(t, off, ext);
            end
            OP_WRITE:
            begin
                if (addr == ADDR_DMA_START)
                begin
                    r.target         = TGT_DMA;
                    r.target_address = ADDR_DMA_START;
                    dma_page         = wd;
                    dma_count        = '0;
                    dma_running      = 1'b1;
                end
                else
                begin
                    map_address(addr, t, off);
                    r.target         = t;
                    r.target_address = off;
                    if (t == TGT_RAM)
                        work_mem[int'(off)] = wd;
                end
                if (r.target != TGT_NONE)
                begin
                    r.is_write = 1'b1;
                    r.out_data = wd;
                end
            end
            OP_DMA_TICK:
            begin
                if (dma_running)
                begin
                    if (int'(dma_count) < DMA_LENGTH_DEF)
                    begin
                        src = {dma_page, 8'h00} + {7'd0, dma_count};
                        map_address(src, t, off);
                        r.read_data      = bus_byte(t, off, ext);
                        r.target         = TGT_PPU;
                        r.target_address = PPU_OAM_DATA;
                        r.is_write       = 1'b1;
                        r.out_data       = r.read_data;
                        r.dma_source     = src;
                        dma_count        = dma_count + 9'd1;
                    end
                    else
                    begin
                        // final tick: end the transfer
                        dma_running = 1'b0;
                        dma_count   = '0;
                    end
                end
            end
            default: ;
        endcase
        r.dma_active = dma_running;
        return r;
    endfunction

    // Send one request word; honor burst gaps on the sender side
    task automatic issue_access(input logic [1:0] op, input logic [15:0] addr,
                                input logic [7:0] wd, input logic [7:0] ext);
        if (gaps_on && burst_left <= 0)
        begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        req_bus.valid         <= 1'b1;
        req_bus.operation     <= op;
        req_bus.address       <= addr;
        req_bus.write_data    <= wd;
        req_bus.external_data <= ext;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        expected_routes.push_back(route_access(op, addr, wd, ext));
        items_sent++;
        burst_left--;
        @(negedge clk);
    endtask

    // Drop valid and hold until every expected word has come back
    task automatic hold_bus_until_drained();
        req_bus.valid <= 1'b0;
        @(negedge clk);
        while (expected_routes.size() != 0)
            @(negedge clk);
        burst_left = 0;
    endtask

    function automatic logic [15:0] pick_address();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0: return 16'($urandom_range(16'h0000, 16'h1FFF));
            // narrow window with random mirror bits so reads hit written bytes
            1: return {3'b000, r[12:11], 5'b00000, r[5:0]};
            2: return 16'($urandom_range(16'h2000, 16'h3FFF));
            3: return 16'($urandom_range(16'h4000, 16'h401F));
            4: return ADDR_DMA_START;
            5: return 16'($urandom_range(16'h4020, 16'h5FFF));
            6: return 16'($urandom_range(16'h6000, 16'hFFFF));
            default: return r[15:0];
        endcase
    endfunction

    function automatic logic [7:0] pick_page();
        case ($urandom_range(0, 4))
            0: return 8'($urandom_range(8'h00, 8'h1F));
            1: return 8'($urandom_range(8'h20, 8'h3F));
            2: return 8'h40;
            3: return 8'($urandom_range(8'h41, 8'h5F));
            default: return 8'($urandom_range(8'h60, 8'hFF));
        endcase
    endfunction

    task automatic issue_cpu_noise();
        int         pick;
        logic [1:0] op;
        pick = $urandom_range(0, 19);
        if (pick < 9)
            op = OP_READ;
        else if (pick < 17)
            op = OP_WRITE;
        else if (pick < 19)
            op = OP_DMA_TICK;
        else
            op = OP_UNUSED;
        issue_access(op, pick_address(), 8'($urandom), 8'($urandom));
    endtask

    // Start a transfer and tick it, either to the end or cut short
    task automatic issue_dma_sequence();
        int ticks;
        issue_access(OP_WRITE, ADDR_DMA_START, pick_page(), 8'($urandom));
        if ($urandom_range(0, 2) == 0)
            ticks = $urandom_range(1, 80);
        else
            ticks = DMA_LENGTH_DEF + 1 + $urandom_range(0, 1);
        repeat (ticks)
        begin
            if ($urandom_range(0, 9) == 0)
                issue_cpu_noise();
            issue_access(OP_DMA_TICK, 16'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    task automatic test_decode_regions();
        issue_access(OP_READ,     16'h0000, 8'h00, 8'hFF);
        issue_access(OP_READ,     16'h07FF, 8'hFF, 8'h00);
        issue_access(OP_WRITE,    16'h0000, 8'hFF, 8'h00);
        issue_access(OP_WRITE,    16'h1FFF, 8'h5A, 8'hFF);
        issue_access(OP_READ,     16'h0800, 8'h00, 8'h00);
        issue_access(OP_READ,     16'h07FF, 8'h00, 8'h00);
        issue_access(OP_READ,     16'h1800, 8'h00, 8'h00);
        issue_access(OP_READ,     16'h2000, 8'h00, 8'hFF);
        issue_access(OP_WRITE,    16'h3FFF, 8'h00, 8'hFF);
        issue_access(OP_READ,     16'h4000, 8'h00, 8'h81);
        issue_access(OP_WRITE,    16'h401F, 8'hC3, 8'h00);
        issue_access(OP_READ,     ADDR_DMA_START, 8'hFF, 8'hA5);
        issue_access(OP_READ,     16'h4020, 8'hFF, 8'hFF);
        issue_access(OP_WRITE,    16'h5FFF, 8'hFF, 8'hFF);
        issue_access(OP_READ,     16'h6000, 8'h00, 8'h3C);
        issue_access(OP_WRITE,    16'hFFFF, 8'hFF, 8'h00);
        issue_access(OP_READ,     16'hFFFF, 8'h00, 8'hFF);
        issue_access(OP_DMA_TICK, 16'hFFFF, 8'hFF, 8'hFF);
        issue_access(OP_UNUSED,   16'hFFFF, 8'hFF, 8'hFF);
        issue_access(OP_UNUSED,   16'h0000, 8'h00, 8'h00);
    endtask

    task automatic test_dma_transfer();
        issue_access(OP_WRITE, 16'h0300, 8'h11, 8'h00);
        issue_access(OP_WRITE, 16'h0BFF, 8'hEE, 8'h00);
        // page 0x0B mirrors RAM 0x0300
        issue_access(OP_WRITE, ADDR_DMA_START, 8'h0B, 8'h00);
        repeat (DMA_LENGTH_DEF)
            issue_access(OP_DMA_TICK, 16'($urandom), 8'($urandom), 8'($urandom));
        issue_access(OP_DMA_TICK, 16'h0000, 8'hFF, 8'hFF);
        issue_access(OP_DMA_TICK, 16'h0000, 8'hFF, 8'hFF);
    endtask

    task automatic test_dma_restart();
        issue_access(OP_WRITE, ADDR_DMA_START, 8'h21, 8'h00);
        repeat (4)
            issue_access(OP_DMA_TICK, 16'h0000, 8'h00, 8'($urandom));
        issue_access(OP_READ,  16'h0300, 8'h00, 8'h77);
        issue_access(OP_WRITE, 16'h2004, 8'h99, 8'h00);
        issue_access(OP_WRITE, ADDR_DMA_START, 8'h50, 8'h00);
        repeat (3)
            issue_access(OP_DMA_TICK, 16'h0000, 8'h00, 8'hFF);
        issue_access(OP_WRITE, ADDR_DMA_START, 8'hFF, 8'h00);
        repeat (2)
            issue_access(OP_DMA_TICK, 16'h0000, 8'h00, 8'($urandom));
    endtask

    task automatic test_backpressure();
        gaps_on       = 1'b0;
        hold_off_left = 300;
        repeat (48)
            issue_cpu_noise();
        hold_bus_until_drained();
    endtask

    task automatic test_random_traffic();
        int first;
        int mark;
        first = items_sent;
        mark  = items_sent;
        while (items_sent - first < RANDOM_ITEMS)
        begin
            if (items_sent - mark > 200)
            begin
                hold_bus_until_drained();
                gaps_on      = ($urandom_range(0, 3) != 0);
                stall_enable = ($urandom_range(0, 3) != 0);
                mark         = items_sent;
            end
            if ($urandom_range(0, 9) == 0)
                issue_dma_sequence();
            else
                repeat ($urandom_range(1, 20))
                    issue_cpu_noise();
        end
    endtask

    // Receiver pacing: long hold-off on request, else always ready or, with stalls on, alternating runs
    initial
    begin : rsp_pacer
        int run_left;
        bit stalled;
        run_left      = 0;
        stalled       = 1'b0;
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                hold_off_left--;
                rsp_bus.ready <= 1'b0;
            end
            else if (!stall_enable)
                rsp_bus.ready <= 1'b1;
            else
            begin
                if (run_left <= 0)
                begin
                    stalled  = ~stalled;
                    run_left = stalled ? $urandom_range(1, 5) : $urandom_range(1, 14);
                end
                run_left--;
                rsp_bus.ready <= ~stalled;
            end
        end
    end

    initial
    begin : rsp_checker
        route_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_bus.valid && rsp_bus.ready)
            begin
                if (expected_routes.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("%0t: result word with nothing expected: tgt=%0d addr=%h",
                                 $realtime, rsp_bus.target, rsp_bus.target_address);
                end
                else
                begin
                    want = expected_routes.pop_front();
                    if (rsp_bus.target !== want.target ||
                        rsp_bus.target_address !== want.target_address ||
                        rsp_bus.is_write !== want.is_write ||
                        rsp_bus.out_data !== want.out_data ||
                        rsp_bus.read_data !== want.read_data ||
                        rsp_bus.dma_active !== want.dma_active ||
                        rsp_bus.dma_source !== want.dma_source)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX)
                        begin
                            $display("%0t: mismatch exp tgt=%0d addr=%h wr=%0d od=%h rd=%h act=%0d src=%h",
                                     $realtime, want.target, want.target_address, want.is_write,
                                     want.out_data, want.read_data, want.dma_active,
                                     want.dma_source);
                            $display("%0t:          got tgt=%0d addr=%h wr=%0d od=%h rd=%h act=%0d src=%h",
                                     $realtime, rsp_bus.target, rsp_bus.target_address,
                                     rsp_bus.is_write, rsp_bus.out_data, rsp_bus.read_data,
                                     rsp_bus.dma_active, rsp_bus.dma_source);
                        end
                    end
                end
            end
        end
    end

    // Watchdog: end the run once nothing moves for too long
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: timeout, %0d words still expected", $realtime, expected_routes.size());
        $display("status: fail");
        $finish;
    end

    initial
    begin : main_sequence
        rst_n                 = 1'b0;
        req_bus.valid         = 1'b0;
        req_bus.operation     = OP_READ;
        req_bus.address       = '0;
        req_bus.write_data    = '0;
        req_bus.external_data = '0;
        fail_count            = 0;
        items_sent            = 0;
        burst_left            = 0;
        gaps_on               = 1'b1;
        stall_enable          = 1'b1;
        hold_off_left         = 0;
        for (int i = 0; i < RAM_BYTES_DEF; i++)
            work_mem[i] = 8'h00;
        dma_page    = DMA_PAGE_RESET;
        dma_count   = '0;
        dma_running = 1'b0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_decode_regions();
        test_dma_transfer();
        test_dma_restart();
        test_backpressure();
        gaps_on      = 1'b1;
        stall_enable = 1'b1;
        test_random_traffic();

        hold_bus_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_routes.size() != 0)
            $display("%0t: %0d words never arrived", $realtime, expected_routes.size());
        if (fail_count == 0 && expected_routes.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
